>>> rtl/planar_odometry_integrator_defines.svh
// Assertion macros shared by the odometry integrator RTL.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_DEFINES_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define POI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define POI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/poi_pkg.sv
// Types, constants and tables of the planar odometry integrator.
package poi_pkg;

    localparam int ANGLE_BITS   = 32;
    localparam int CORDIC_STEPS = 16;
    localparam int XY_W         = 34;
    localparam int IDX_W        = 5;
    localparam int Q_W          = 34;
    localparam int VMAG_W       = 32;
    localparam int MAC_LAST     = 3;
    localparam int MULV_LAST    = 1;
    localparam int HMUL_LAST    = 3;
    localparam int DIV_LAST     = 3;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
    localparam logic [63:0] POS_HALF   = 64'd1024000000;
    // 2048000000 = 2^17 * 15625; ceil(2^60 / 15625), exact for 46-bit dividends
    localparam logic [46:0] POS_RECIP  = 47'd73786976294839;
    localparam logic [36:0] HEAD_MULT  = 37'd91746578228;

    typedef struct packed {
        logic signed [15:0] linear_velocity;
        logic signed [15:0] angular_velocity;
        logic [31:0]        sample_time;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic [31:0]        heading_angle;
        logic signed [15:0] echo_linear;
        logic signed [15:0] echo_angular;
        logic [31:0]        result_time;
    } pose_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_PRIME, OP_LOAD, OP_ROT, OP_MAC, OP_ABS,
        OP_MULV, OP_HMUL, OP_DIV, OP_UPD
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ROT, ST_MAC, ST_ABS, ST_MULV, ST_HMUL, ST_DIV, ST_UPD
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic primed;
    } status_t;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/poi_cordic.sv
// Iterative rotation-mode CORDIC, one step per cycle while step is high, with quadrant fold.
module poi_cordic (
    input  logic                             clk,
    input  logic                             init,
    input  logic [31:0]                      angle,
    input  logic                             step,
    input  logic [4:0]                       idx,
    output logic signed [poi_pkg::XY_W-1:0]  cos_val,
    output logic signed [poi_pkg::XY_W-1:0]  sin_val
);

    logic signed [poi_pkg::XY_W-1:0] x_reg, x_next;
    logic signed [poi_pkg::XY_W-1:0] y_reg, y_next;
    logic signed [poi_pkg::XY_W-1:0] z_reg, z_next;
    logic                            flip_reg, flip_next;

    always_comb
    begin
        logic [31:0] a;
        logic signed [poi_pkg::XY_W-1:0] dx;
        logic signed [poi_pkg::XY_W-1:0] dy;
        logic signed [poi_pkg::XY_W-1:0] at;
        a = angle & poi_pkg::ANGLE_MASK;
        dx = y_reg >>> idx;
        dy = x_reg >>> idx;
        at = signed'({{(poi_pkg::XY_W-32){1'b0}}, poi_pkg::atan_entry(idx)});
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        flip_next = flip_reg;
        if (init)
        begin
            // fold into the right half plane; negate the results at the end
            flip_next = a[31] ^ a[30];
            if (flip_next)
            begin
                a = a + 32'h80000000;
            end
            x_next = poi_pkg::CORDIC_GAIN;
            y_next = '0;
            z_next = signed'({{(poi_pkg::XY_W-32){a[31]}}, a});
        end
        else if (step)
        begin
            if (!z_reg[poi_pkg::XY_W-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign cos_val = flip_reg ? -x_reg : x_reg;
    assign sin_val = flip_reg ? -y_reg : y_reg;

endmodule

>>> rtl/poi_datapath.sv
// Datapath: pose state, trig units, multiplies, reciprocal divider, output register.
module poi_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  poi_pkg::cmd_t     cmd,
    input  poi_pkg::sample_t  sample,
    output poi_pkg::status_t  status,
    output poi_pkg::pose_t    pose
);

    localparam int XW = poi_pkg::XY_W;

    // architectural state
    logic               primed_reg;
    logic signed [15:0] prev_lin_reg, prev_ang_reg;
    logic [31:0]        prev_time_reg;
    logic signed [31:0] pose_x_reg, pose_y_reg;
    logic [31:0]        heading_reg, older_reg;

    // working registers
    logic signed [15:0]   lin_reg, ang_reg;
    logic [31:0]          time_reg, dt_reg;
    logic signed [16:0]   w_reg;
    logic signed [50:0]   accx_reg, accy_reg;
    logic [poi_pkg::VMAG_W-1:0] magx_reg, magy_reg;
    logic                 negx_reg, negy_reg, negw_reg;
    logic [48:0]          pw_reg;
    logic [63:0]          nx_reg, ny_reg;
    logic [71:0]          hacc_reg;
    logic [93:0]          qacx_reg, qacy_reg;
    poi_pkg::pose_t       pose_reg;

    logic signed [XW-1:0] c_now, s_now, c_old, s_old;
    logic cordic_init, cordic_step;

    assign cordic_init = (cmd.op == poi_pkg::OP_LOAD);
    assign cordic_step = (cmd.op == poi_pkg::OP_ROT);

    poi_cordic u_cordic_now (
        .clk     (clk),
        .init    (cordic_init),
        .angle   (heading_reg),
        .step    (cordic_step),
        .idx     (cmd.idx),
        .cos_val (c_now),
        .sin_val (s_now)
    );

    poi_cordic u_cordic_old (
        .clk     (clk),
        .init    (cordic_init),
        .angle   (older_reg),
        .step    (cordic_step),
        .idx     (cmd.idx),
        .cos_val (c_old),
        .sin_val (s_old)
    );

    // shared velocity multiplier
    logic signed [15:0]    mac_a;
    logic signed [XW-1:0]  mac_b;
    logic signed [49:0]    mac_p;
    always_comb
    begin
        case (cmd.idx[1:0])
            2'd0: begin mac_a = lin_reg;      mac_b = c_now; end
            2'd1: begin mac_a = prev_lin_reg; mac_b = c_old; end
            2'd2: begin mac_a = lin_reg;      mac_b = s_now; end
            default: begin mac_a = prev_lin_reg; mac_b = s_old; end
        endcase
        mac_p = mac_a * mac_b;
    end

    // velocity magnitudes, heading rate product
    logic signed [34:0] vx, vy;
    logic [16:0]        wabs;
    assign vx   = 35'(accx_reg >>> 16);
    assign vy   = 35'(accy_reg >>> 16);
    assign wabs = w_reg[16] ? 17'(-w_reg) : 17'(w_reg);

    // heading partial products: pw * M modulo 2^72
    logic [24:0] hp_a;
    logic [18:0] hp_b;
    logic [43:0] hp_p;
    logic [71:0] hp_s;
    always_comb
    begin
        case (cmd.idx[1:0])
            2'd0: begin hp_a = pw_reg[24:0];          hp_b = poi_pkg::HEAD_MULT[18:0]; end
            2'd1: begin hp_a = pw_reg[24:0];          hp_b = {1'b0, poi_pkg::HEAD_MULT[36:19]}; end
            2'd2: begin hp_a = {1'b0, pw_reg[48:25]}; hp_b = poi_pkg::HEAD_MULT[18:0]; end
            default: begin hp_a = {1'b0, pw_reg[48:25]}; hp_b = {1'b0, poi_pkg::HEAD_MULT[36:19]}; end
        endcase
        hp_p = hp_a * hp_b;
        case (cmd.idx[1:0])
            2'd0: hp_s = {28'd0, hp_p};
            2'd1: hp_s = {28'd0, hp_p} << 19;
            2'd2: hp_s = {28'd0, hp_p} << 25;
            default: hp_s = {28'd0, hp_p} << 44;
        endcase
    end

    // quotient by 2048000000: (n >> 17) * recip >> 60, one partial product per lane a cycle
    logic [22:0] rm_ax, rm_ay;
    logic [23:0] rm_b;
    logic [46:0] rm_px, rm_py;
    logic [93:0] rm_sx, rm_sy;
    always_comb
    begin
        case (cmd.idx[1:0])
            2'd0:
            begin
                rm_ax = nx_reg[39:17];
                rm_ay = ny_reg[39:17];
                rm_b  = poi_pkg::POS_RECIP[23:0];
            end
            2'd1:
            begin
                rm_ax = nx_reg[39:17];
                rm_ay = ny_reg[39:17];
                rm_b  = {1'b0, poi_pkg::POS_RECIP[46:24]};
            end
            2'd2:
            begin
                rm_ax = nx_reg[62:40];
                rm_ay = ny_reg[62:40];
                rm_b  = poi_pkg::POS_RECIP[23:0];
            end
            default:
            begin
                rm_ax = nx_reg[62:40];
                rm_ay = ny_reg[62:40];
                rm_b  = {1'b0, poi_pkg::POS_RECIP[46:24]};
            end
        endcase
        rm_px = rm_ax * rm_b;
        rm_py = rm_ay * rm_b;
        case (cmd.idx[1:0])
            2'd0:
            begin
                rm_sx = {47'd0, rm_px};
                rm_sy = {47'd0, rm_py};
            end
            2'd1:
            begin
                rm_sx = {47'd0, rm_px} << 24;
                rm_sy = {47'd0, rm_py} << 24;
            end
            2'd2:
            begin
                rm_sx = {47'd0, rm_px} << 23;
                rm_sy = {47'd0, rm_py} << 23;
            end
            default:
            begin
                rm_sx = {47'd0, rm_px} << 47;
                rm_sy = {47'd0, rm_py} << 47;
            end
        endcase
    end

    // final update values
    logic signed [31:0] x_new, y_new;
    logic [31:0]        hstep;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                   input logic [poi_pkg::Q_W-1:0] q,
                                                   input logic neg);
        logic signed [35:0] s;
        logic signed [35:0] d;
        d = signed'({2'b00, q});
        s = neg ? (36'(p) - d) : (36'(p) + d);
        if (s > 36'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (s < -36'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    assign x_new = sat_add(pose_x_reg, qacx_reg[93:60], negx_reg);
    assign y_new = sat_add(pose_y_reg, qacy_reg[93:60], negy_reg);
    assign hstep = negw_reg ? (32'd0 - hacc_reg[71:40]) : hacc_reg[71:40];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg    <= 1'b0;
            prev_lin_reg  <= '0;
            prev_ang_reg  <= '0;
            prev_time_reg <= '0;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            heading_reg   <= '0;
            older_reg     <= '0;
        end
        else
        begin
            if (cmd.op == poi_pkg::OP_PRIME)
            begin
                primed_reg    <= 1'b1;
                prev_lin_reg  <= sample.linear_velocity;
                prev_ang_reg  <= sample.angular_velocity;
                prev_time_reg <= sample.sample_time;
            end
            else if (cmd.op == poi_pkg::OP_UPD)
            begin
                prev_lin_reg  <= lin_reg;
                prev_ang_reg  <= ang_reg;
                prev_time_reg <= time_reg;
                pose_x_reg    <= x_new;
                pose_y_reg    <= y_new;
                older_reg     <= heading_reg;
                heading_reg   <= heading_reg + hstep;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            poi_pkg::OP_LOAD:
            begin
                lin_reg  <= sample.linear_velocity;
                ang_reg  <= sample.angular_velocity;
                time_reg <= sample.sample_time;
                dt_reg   <= sample.sample_time - prev_time_reg;
                w_reg    <= 17'(sample.angular_velocity) + 17'(prev_ang_reg);
            end
            poi_pkg::OP_MAC:
            begin
                if (cmd.idx[1:0] == 2'd0)
                begin
                    accx_reg <= 51'(mac_p);
                end
                else if (cmd.idx[1:0] == 2'd1)
                begin
                    accx_reg <= accx_reg + 51'(mac_p);
                end
                else if (cmd.idx[1:0] == 2'd2)
                begin
                    accy_reg <= 51'(mac_p);
                end
                else
                begin
                    accy_reg <= accy_reg + 51'(mac_p);
                end
            end
            poi_pkg::OP_ABS:
            begin
                negx_reg <= vx[34];
                negy_reg <= vy[34];
                negw_reg <= w_reg[16];
                magx_reg <= poi_pkg::VMAG_W'(vx[34] ? -vx : vx);
                magy_reg <= poi_pkg::VMAG_W'(vy[34] ? -vy : vy);
                pw_reg   <= {32'd0, wabs} * {17'd0, dt_reg};
            end
            poi_pkg::OP_MULV:
            begin
                // magnitude times dt, plus half the divisor for rounding
                if (cmd.idx[0] == 1'b0)
                begin
                    nx_reg <= 64'({32'd0, magx_reg} * {32'd0, dt_reg}) + poi_pkg::POS_HALF;
                end
                else
                begin
                    ny_reg <= 64'({32'd0, magy_reg} * {32'd0, dt_reg}) + poi_pkg::POS_HALF;
                end
            end
            poi_pkg::OP_HMUL:
            begin
                if (cmd.idx[1:0] == 2'd0)
                begin
                    hacc_reg <= (72'd1 << 39) + hp_s;
                end
                else
                begin
                    hacc_reg <= hacc_reg + hp_s;
                end
            end
            poi_pkg::OP_DIV:
            begin
                if (cmd.idx[1:0] == 2'd0)
                begin
                    qacx_reg <= rm_sx;
                    qacy_reg <= rm_sy;
                end
                else
                begin
                    qacx_reg <= qacx_reg + rm_sx;
                    qacy_reg <= qacy_reg + rm_sy;
                end
            end
            poi_pkg::OP_UPD:
            begin
                pose_reg.position_x    <= x_new;
                pose_reg.position_y    <= y_new;
                pose_reg.heading_angle <= heading_reg + hstep;
                pose_reg.echo_linear   <= lin_reg;
                pose_reg.echo_angular  <= ang_reg;
                pose_reg.result_time   <= time_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.primed = primed_reg;
    assign pose          = pose_reg;

endmodule

>>> rtl/poi_controller.sv
// Sequencer: steps the datapath through trig, multiply and divide phases.
module poi_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    output logic              pose_valid,
    input  logic              pose_stall,
    input  poi_pkg::status_t  status,
    output poi_pkg::cmd_t     cmd
);

    localparam int IW = poi_pkg::IDX_W;

    poi_pkg::state_t  state_reg, state_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic             valid_reg, valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= poi_pkg::ST_IDLE;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        valid_next   = valid_reg && pose_stall;
        sample_stall = 1'b1;
        cmd.op       = poi_pkg::OP_NONE;
        cmd.idx      = idx_reg;
        unique case (state_reg)
            poi_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
                if (sample_valid)
                begin
                    if (status.primed)
                    begin
                        cmd.op     = poi_pkg::OP_LOAD;
                        state_next = poi_pkg::ST_ROT;
                        idx_next   = '0;
                    end
                    else
                    begin
                        cmd.op = poi_pkg::OP_PRIME;
                    end
                end
            end
            poi_pkg::ST_ROT:
            begin
                cmd.op = poi_pkg::OP_ROT;
                if (idx_reg == IW'(poi_pkg::CORDIC_STEPS - 1))
                begin
                    state_next = poi_pkg::ST_MAC;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            poi_pkg::ST_MAC:
            begin
                cmd.op = poi_pkg::OP_MAC;
                if (idx_reg == IW'(poi_pkg::MAC_LAST))
                begin
                    state_next = poi_pkg::ST_ABS;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            poi_pkg::ST_ABS:
            begin
                cmd.op     = poi_pkg::OP_ABS;
                state_next = poi_pkg::ST_MULV;
                idx_next   = '0;
            end
            poi_pkg::ST_MULV:
            begin
                cmd.op = poi_pkg::OP_MULV;
                if (idx_reg == IW'(poi_pkg::MULV_LAST))
                begin
                    state_next = poi_pkg::ST_HMUL;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            poi_pkg::ST_HMUL:
            begin
                cmd.op = poi_pkg::OP_HMUL;
                if (idx_reg == IW'(poi_pkg::HMUL_LAST))
                begin
                    state_next = poi_pkg::ST_DIV;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            poi_pkg::ST_DIV:
            begin
                cmd.op = poi_pkg::OP_DIV;
                if (idx_reg == IW'(poi_pkg::DIV_LAST))
                begin
                    state_next = poi_pkg::ST_UPD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            poi_pkg::ST_UPD:
            begin
                // commit only when the output register is free or draining
                if (!(valid_reg && pose_stall))
                begin
                    cmd.op     = poi_pkg::OP_UPD;
                    valid_next = 1'b1;
                    state_next = poi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = poi_pkg::ST_IDLE;
            end
        endcase
    end

    assign pose_valid = valid_reg;

endmodule

>>> rtl/planar_odometry_integrator.sv
// Top level of the planar odometry integrator.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-----------------------
//  input    | sample_valid | sample_stall | sample (sample_t)
//  output   | pose_valid   | pose_stall   | pose   (pose_t)
//
// After acceptance a primed sample passes through 16 CORDIC steps (both
// angles in parallel), the multiply phases, the reciprocal divide and the
// commit; the input stays stalled until the controller is back in idle.
// The first sample after reset only primes the state.
// Reset at once clears pose state, stored sample and output valid, not pose_reg.
// A stalled result holds; the next sample is accepted meanwhile, and its
// commit waits until the output register drains.
`include "planar_odometry_integrator_defines.svh"

module planar_odometry_integrator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  poi_pkg::sample_t  sample,
    output logic              pose_valid,
    input  logic              pose_stall,
    output poi_pkg::pose_t    pose
);

    poi_pkg::cmd_t    cmd;
    poi_pkg::status_t status;

    poi_controller u_controller (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .pose_valid   (pose_valid),
        .pose_stall   (pose_stall),
        .status       (status),
        .cmd          (cmd)
    );

    poi_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sample (sample),
        .status (status),
        .pose   (pose)
    );

    `POI_ASSERT_NOW(a_no_result_unprimed, clk, rst_n, !status.primed, !pose_valid, "result before priming")
    `POI_ASSERT_NEXT(a_busy_after_load, clk, rst_n, sample_valid && !sample_stall && status.primed, sample_stall, "sample taken while busy")
    `POI_ASSERT_NEXT(a_commit_sets_valid, clk, rst_n, cmd.op == poi_pkg::OP_UPD, pose_valid, "commit lost")

endmodule
